// File: rtl/bas_pkg.sv
// Shared constants, types and state codes for the split-only buddy allocator.
// No dependencies; every other file imports this package.
package bas_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ORD_W      = 5;
	localparam int OWN_W      = 16;
	localparam int SIZE_W     = 31;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam logic KIND_ALLOCATE = 1'b0;

	typedef struct packed {
		logic              kind;
		logic [OWN_W-1:0]  owner_id;
		logic [SIZE_W-1:0] request_size;
		logic [IDX_W-1:0]  block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] block_count;
		logic [OWN_W-1:0] owner_at_index;
	} rsp_t;

	typedef struct packed {
		logic [ORD_W-1:0] order;
		logic [OWN_W-1:0] owner;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_GRANT,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FILL,
		S_RES_RD,
		S_RES
	} state_t;

	typedef struct packed {
		logic init;
		logic load;
		logic chk_adv;
		logic grant;
		logic decide;
		logic shift_wr;
		logic fill;
		logic rd_idx;
		logic res;
	} cmd_t;

	typedef struct packed {
		logic             is_query;
		logic             exact_hit;
		logic             scan_last;
		logic             found;
		logic             overflow;
		logic             tail_empty;
		logic             shift_last;
		logic             fill_last;
		logic             out_busy;
		logic [CNT_W-1:0] total;
	} stat_t;

endpackage

// File: rtl/bas_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on bas_pkg.
interface bas_req_if;
	import bas_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bas_rsp_if;
	import bas_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bas_cfg_if;
	import bas_pkg::*;
	logic             valid;
	logic             ready;
	logic [ORD_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bas_ctrl.sv
// Controller state machine sequencing scan, split, shift and result steps.
// Depends on bas_pkg.
module bas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           cfg_valid,
	input  bas_pkg::stat_t stat,
	output bas_pkg::cmd_t  cmd,
	output logic           in_ready
);
	import bas_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:     state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (stat.is_query) state_d = S_RES_RD;
				else state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (stat.exact_hit) state_d = S_GRANT;
				else if (stat.scan_last) state_d = S_DECIDE;
				else state_d = S_SCAN_RD;
			end
			S_GRANT:    state_d = S_RES_RD;
			S_DECIDE: begin
				if (!stat.found || stat.overflow) state_d = S_RES_RD;
				else if (stat.tail_empty) state_d = S_FILL;
				else state_d = S_SHIFT_RD;
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (stat.shift_last) state_d = S_FILL;
				else state_d = S_SHIFT_RD;
			end
			S_FILL: begin
				if (stat.fill_last) state_d = S_RES_RD;
			end
			S_RES_RD:   state_d = S_RES;
			S_RES: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default:    state_d = S_INIT;
		endcase
		if (cfg_valid) state_d = S_INIT;
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: cmd.init = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN_CHK: cmd.chk_adv = !stat.exact_hit;
			S_GRANT:    cmd.grant = 1'b1;
			S_DECIDE:   cmd.decide = 1'b1;
			S_SHIFT_WR: cmd.shift_wr = 1'b1;
			S_FILL:     cmd.fill = 1'b1;
			S_RES_RD:   cmd.rd_idx = 1'b1;
			S_RES: begin
				cmd.rd_idx = 1'b1;
				cmd.res    = !stat.out_busy;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/bas_dp.sv
// Datapath: block list memory, scan pointer, split bookkeeping and result register.
// Depends on bas_pkg.
module bas_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bas_pkg::cmd_t             cmd,
	input  bas_pkg::req_t             req_data,
	input  logic                      cfg_valid,
	input  logic [bas_pkg::ORD_W-1:0] cfg_data,
	input  logic                      rsp_ready,
	output bas_pkg::stat_t            stat,
	output logic                      rsp_valid,
	output bas_pkg::rsp_t             rsp_data
);
	import bas_pkg::*;

	entry_t           mem [MAX_BLOCKS];
	entry_t           rdata_q;
	logic [IDX_W-1:0] raddr, waddr;
	entry_t           wdata;
	logic             we;

	logic [ORD_W-1:0] total_order_q;
	logic [CNT_W-1:0] total_q;
	logic             kind_q;
	logic [OWN_W-1:0] owner_q;
	logic [IDX_W-1:0] idx_q;
	logic [ORD_W-1:0] r_q;
	logic [IDX_W-1:0] ptr_q;
	logic             found_q;
	logic [IDX_W-1:0] li_q;
	logic [ORD_W-1:0] lo_q;
	logic [ORD_W-1:0] j_q;
	logic [1:0]       status_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic [ORD_W-1:0] d;
	logic [CNT_W:0]   grown;
	logic             is_free;
	logic [ORD_W-1:0] r_in;
	logic [SIZE_W-1:0] size_m1;

	always_comb begin
		size_m1 = req_data.request_size - SIZE_W'(1);
		r_in    = '0;
		if (req_data.request_size > SIZE_W'(1)) begin
			for (int b = 0; b < SIZE_W; b++) begin
				if (size_m1[b]) r_in = ORD_W'(b + 1);
			end
		end
	end

	assign d       = lo_q - r_q;
	assign grown   = {1'b0, total_q} + (CNT_W + 1)'(d);
	assign is_free = (rdata_q.owner == '0);

	assign stat.is_query   = (kind_q != KIND_ALLOCATE);
	assign stat.exact_hit  = is_free && (rdata_q.order == r_q);
	assign stat.scan_last  = ({1'b0, ptr_q} + CNT_W'(1)) == total_q;
	assign stat.found      = found_q;
	assign stat.overflow   = grown > (CNT_W + 1)'(MAX_BLOCKS);
	assign stat.tail_empty = (total_q - CNT_W'(1)) == {1'b0, li_q};
	assign stat.shift_last = ptr_q == (li_q + IDX_W'(1));
	assign stat.fill_last  = j_q == d;
	assign stat.out_busy   = out_valid_q && !rsp_ready;
	assign stat.total      = total_q;

	always_comb begin
		raddr = cmd.rd_idx ? idx_q : ptr_q;
		we    = 1'b0;
		waddr = ptr_q;
		wdata = '{order: r_q, owner: owner_q};
		if (cmd.init) begin
			we    = 1'b1;
			waddr = '0;
			wdata = '{order: total_order_q, owner: '0};
		end else if (cmd.grant) begin
			we = 1'b1;
		end else if (cmd.shift_wr) begin
			we    = 1'b1;
			waddr = ptr_q + IDX_W'(d);
			wdata = rdata_q;
		end else if (cmd.fill) begin
			we    = 1'b1;
			waddr = li_q + IDX_W'(j_q);
			if (j_q != '0) wdata = '{order: r_q + j_q - ORD_W'(1), owner: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_order_q <= ORD_W'(10);
			total_q       <= CNT_W'(1);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) total_order_q <= cfg_data;
			if (cmd.init) total_q <= CNT_W'(1);
			if (cmd.fill && stat.fill_last) total_q <= grown[CNT_W-1:0];
			if (cmd.res) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= req_data.kind;
			owner_q  <= req_data.owner_id;
			idx_q    <= req_data.block_index;
			r_q      <= r_in;
			ptr_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
		end
		if (cmd.chk_adv) begin
			if (is_free && rdata_q.order > r_q && !found_q) begin
				found_q <= 1'b1;
				li_q    <= ptr_q;
				lo_q    <= rdata_q.order;
			end
			ptr_q <= ptr_q + IDX_W'(1);
		end
		if (cmd.decide) begin
			if (!found_q) status_q <= ST_NO_FIT;
			else if (stat.overflow) status_q <= ST_OVERFLOW;
			ptr_q <= IDX_W'(total_q - CNT_W'(1));
			j_q   <= '0;
		end
		if (cmd.shift_wr) ptr_q <= ptr_q - IDX_W'(1);
		if (cmd.fill) j_q <= j_q + ORD_W'(1);
		if (cmd.res) begin
			out_q.status         <= status_q;
			out_q.block_count    <= total_q;
			out_q.owner_at_index <= ({1'b0, idx_q} < total_q) ? rdata_q.owner : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

// File: rtl/buddy_allocator_split_only_top.sv
// Split-only buddy allocator: one result word per request word.
// A request scans the listed blocks; a split first shifts the tail blocks up,
// then writes the granted block and one free buddy per halving.
// One word is in flight at a time; the list memory has one read and one write port.
// Reset (and any total_order write) rebuilds the list as one free block;
// total_order resets to 10.
module buddy_allocator_split_only_top (
	input  logic clk,
	input  logic arst_n,
	bas_req_if.sink   req,
	bas_rsp_if.source rsp,
	bas_cfg_if.sink   cfg
);
	import bas_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	bas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.cfg_valid (cfg_fire),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (req.ready)
	);

	bas_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req.data),
		.cfg_valid (cfg_fire),
		.cfg_data  (cfg.data),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data)
	);

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.total != '0 && stat.total <= CNT_W'(MAX_BLOCKS))
		else $error("block count out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");

	a_rebuild_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> !req.ready)
		else $error("request taken during rebuild");

endmodule
